// File: design/mmhf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhf_pkg
// Shared types and constants for the masked median hole fill block.
// ----------------------------------------------------------------------------
package mmhf_pkg;

  localparam int HEIGHT_BITS    = 24;
  localparam int MAX_ROW_LENGTH = 8192;
  localparam int MAX_ROWS       = 8192;
  localparam int MIN_DIM        = 16;
  localparam int DIM_BITS       = 14;
  localparam int COL_BITS       = $clog2(MAX_ROW_LENGTH);
  localparam int ROW_BITS       = $clog2(MAX_ROWS);
  localparam int TOTAL_BITS     = $clog2(MAX_ROW_LENGTH) + $clog2(MAX_ROWS) + 1;
  localparam int POS_BITS       = TOTAL_BITS + 1;
  localparam int LAG_BITS       = COL_BITS + 2;
  localparam int SLOTS          = 4;
  localparam int TAPS           = 9;
  localparam int RANK_BITS      = 4;
  localparam int FILL_MIN       = 3;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PASS_MODE  = 2'd2;

  typedef struct packed {
    logic                          valid;
    logic signed [HEIGHT_BITS-1:0] h;
  } cell_t;

  typedef cell_t [SLOTS-1:0] line_word_t;

  typedef struct packed {
    logic smooth;
    logic center_ok;
    logic spanned;
    logic last;
  } med_ctl_t;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] h;
    logic                          valid;
    logic                          filled;
    logic                          last;
  } result_t;

endpackage

// File: design/masked_median_hole_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_median_hole_fill
// One raster pass of masked 3x3 median hole fill or smoothing.
// ----------------------------------------------------------------------------
// Takes one cell per clock unless the output stalls or frame sizes settle.
// Each item reads one word of the line store (four row slots of one column)
// at acceptance and writes it back from stage 1; a column is revisited only
// a full row later, so the read-modify-write never overlaps. A result leaves
// two rows plus two cells after its input, via stage 1, the median and output
// registers; send flush items to drain the end of a frame. After reset and
// every configuration write the input is stalled while frame sizes settle.
module masked_median_hole_fill (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    kind,
  input  logic signed [mmhf_pkg::HEIGHT_BITS-1:0] height_in,
  input  logic                                    valid_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mmhf_pkg::HEIGHT_BITS-1:0] height_out,
  output logic                                    valid_out,
  output logic                                    was_filled,
  output logic                                    frame_last,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mmhf_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [mmhf_pkg::DIM_BITS-1:0]           cfg_data
);

  // configuration
  logic [mmhf_pkg::DIM_BITS-1:0]   row_length, row_count;
  logic                            pass_mode;
  logic [mmhf_pkg::DIM_BITS-1:0]   l_clamp, r_clamp;
  logic [mmhf_pkg::TOTAL_BITS-1:0] total;
  logic [mmhf_pkg::LAG_BITS-1:0]   lag;
  logic [mmhf_pkg::COL_BITS-1:0]   lm1, lm2, lm3;
  logic [mmhf_pkg::ROW_BITS-1:0]   rm2, rm3;
  logic [1:0]                      settle;
  logic                            cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    if (row_length < mmhf_pkg::DIM_BITS'(mmhf_pkg::MIN_DIM)) begin
      l_clamp = mmhf_pkg::DIM_BITS'(mmhf_pkg::MIN_DIM);
    end else if (row_length > mmhf_pkg::DIM_BITS'(mmhf_pkg::MAX_ROW_LENGTH)) begin
      l_clamp = mmhf_pkg::DIM_BITS'(mmhf_pkg::MAX_ROW_LENGTH);
    end else begin
      l_clamp = row_length;
    end
    if (row_count < mmhf_pkg::DIM_BITS'(mmhf_pkg::MIN_DIM)) begin
      r_clamp = mmhf_pkg::DIM_BITS'(mmhf_pkg::MIN_DIM);
    end else if (row_count > mmhf_pkg::DIM_BITS'(mmhf_pkg::MAX_ROWS)) begin
      r_clamp = mmhf_pkg::DIM_BITS'(mmhf_pkg::MAX_ROWS);
    end else begin
      r_clamp = row_count;
    end
  end

  always_ff @(posedge clk) begin
    total <= mmhf_pkg::TOTAL_BITS'(l_clamp) * mmhf_pkg::TOTAL_BITS'(r_clamp);
    lag   <= mmhf_pkg::LAG_BITS'({l_clamp, 1'b0}) + mmhf_pkg::LAG_BITS'(2);
    lm1   <= mmhf_pkg::COL_BITS'(l_clamp - mmhf_pkg::DIM_BITS'(1));
    lm2   <= mmhf_pkg::COL_BITS'(l_clamp - mmhf_pkg::DIM_BITS'(2));
    lm3   <= mmhf_pkg::COL_BITS'(l_clamp - mmhf_pkg::DIM_BITS'(3));
    rm2   <= mmhf_pkg::ROW_BITS'(r_clamp - mmhf_pkg::DIM_BITS'(2));
    rm3   <= mmhf_pkg::ROW_BITS'(r_clamp - mmhf_pkg::DIM_BITS'(3));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= mmhf_pkg::DIM_BITS'(mmhf_pkg::MAX_ROW_LENGTH);
      row_count  <= mmhf_pkg::DIM_BITS'(mmhf_pkg::MAX_ROWS);
      pass_mode  <= 1'b0;
      settle     <= 2'd2;
    end else if (cfg_wr) begin
      settle <= 2'd2;
      case (cfg_index)
        mmhf_pkg::REG_ROW_LENGTH: row_length <= cfg_data;
        mmhf_pkg::REG_ROW_COUNT:  row_count  <= cfg_data;
        mmhf_pkg::REG_PASS_MODE:  pass_mode  <= cfg_data[0];
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // flow control: everything holds while a result waits to be taken
  logic freeze, adv, acc, take;
  assign freeze   = out_valid && out_stall;
  assign adv      = !freeze;
  assign in_stall = freeze || (settle != 2'd0);
  assign acc      = in_valid && !in_stall;

  // input raster bookkeeping
  logic [mmhf_pkg::POS_BITS-1:0]   pos;
  logic [mmhf_pkg::COL_BITS-1:0]   col;
  logic [1:0]                      slot;
  logic [mmhf_pkg::TOTAL_BITS-1:0] opos;
  logic [mmhf_pkg::COL_BITS-1:0]   out_col;
  logic [mmhf_pkg::ROW_BITS-1:0]   out_row;
  logic                            emit, last;
  mmhf_pkg::cell_t                 nc;

  assign take = acc && !((pos == '0) && kind);
  assign emit = pos >= mmhf_pkg::POS_BITS'(lag);
  assign last = emit && ((opos + mmhf_pkg::TOTAL_BITS'(1)) >= total);

  always_comb begin
    nc.valid = !kind && (pos < mmhf_pkg::POS_BITS'(total)) && valid_in;
    nc.h     = nc.valid ? height_in : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      pos     <= '0;
      col     <= '0;
      slot    <= '0;
      opos    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      if (last) begin
        pos     <= '0;
        col     <= '0;
        slot    <= '0;
        opos    <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        pos <= pos + mmhf_pkg::POS_BITS'(1);
        if (col == lm1) begin
          col  <= '0;
          slot <= slot + 2'd1;
        end else begin
          col <= col + mmhf_pkg::COL_BITS'(1);
        end
        if (emit) begin
          opos <= opos + mmhf_pkg::TOTAL_BITS'(1);
          if (out_col == lm1) begin
            out_col <= '0;
            out_row <= out_row + mmhf_pkg::ROW_BITS'(1);
          end else begin
            out_col <= out_col + mmhf_pkg::COL_BITS'(1);
          end
        end
      end
    end
  end

  // stage 1: line store read in flight
  logic                          s1_valid, s1_emit, s1_last;
  mmhf_pkg::cell_t               s1_cell;
  logic [mmhf_pkg::COL_BITS-1:0] s1_col;
  logic [1:0]                    s1_slot;
  logic [4:0]                    s1_rowok, s1_colok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cell     <= nc;
      s1_col      <= col;
      s1_slot     <= slot;
      s1_emit     <= emit;
      s1_last     <= last;
      s1_rowok[0] <= out_row >= mmhf_pkg::ROW_BITS'(2);
      s1_rowok[1] <= out_row >= mmhf_pkg::ROW_BITS'(1);
      s1_rowok[2] <= 1'b1;
      s1_rowok[3] <= out_row <= rm2;
      s1_rowok[4] <= out_row <= rm3;
      s1_colok[0] <= out_col >= mmhf_pkg::COL_BITS'(2);
      s1_colok[1] <= out_col >= mmhf_pkg::COL_BITS'(1);
      s1_colok[2] <= 1'b1;
      s1_colok[3] <= out_col <= lm2;
      s1_colok[4] <= out_col <= lm3;
    end
  end

  mmhf_pkg::line_word_t rdata, wdata;
  logic                 mem_we;

  assign mem_we = adv && s1_valid;

  always_comb begin
    wdata          = rdata;
    wdata[s1_slot] = s1_cell;
  end

  mmhf_line_mem u_line_mem (
    .clk   (clk),
    .re    (take),
    .raddr (col),
    .rdata (rdata),
    .we    (mem_we),
    .waddr (s1_col),
    .wdata (wdata)
  );

  // 5x5 window: row 0 oldest, column 4 newest
  mmhf_pkg::cell_t win [5][5];
  mmhf_pkg::cell_t sh  [5][5];
  logic            p   [5][5];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      for (int k = 0; k < 4; k++) begin
        sh[i][k] = win[i][k+1];
      end
    end
    for (int i = 0; i < 4; i++) begin
      sh[i][4] = rdata[2'(s1_slot + 2'(i))];
    end
    sh[4][4] = s1_cell;
    for (int i = 0; i < 5; i++) begin
      for (int k = 0; k < 5; k++) begin
        p[i][k] = sh[i][k].valid && s1_rowok[i] && s1_colok[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr || (mem_we && s1_last)) begin
      for (int i = 0; i < 5; i++) begin
        for (int k = 0; k < 5; k++) begin
          win[i][k] <= '0;
        end
      end
    end else if (mem_we) begin
      win <= sh;
    end
  end

  // median stage inputs
  logic signed [mmhf_pkg::HEIGHT_BITS-1:0] vals [mmhf_pkg::TAPS];
  logic [mmhf_pkg::TAPS-1:0]               mask;
  mmhf_pkg::med_ctl_t                      ctl;
  mmhf_pkg::result_t                       res;
  logic                                    m_valid;

  always_comb begin
    for (int j = 0; j < mmhf_pkg::TAPS; j++) begin
      vals[j] = sh[1 + j / 3][1 + j % 3].h;
      mask[j] = p[1 + j / 3][1 + j % 3];
    end
    if (!pass_mode) begin
      mask[4] = 1'b0;
    end
    ctl.smooth    = pass_mode;
    ctl.center_ok = p[2][2];
    ctl.spanned   = ((p[2][1] || p[2][0]) && (p[2][3] || p[2][4])) ||
                    ((p[1][2] || p[0][2]) && (p[3][2] || p[4][2]));
    ctl.last      = s1_last;
  end

  mmhf_median u_median (
    .clk  (clk),
    .en   (adv),
    .vals (vals),
    .mask (mask),
    .ctl  (ctl),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_valid   <= s1_valid && s1_emit;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      height_out <= res.h;
      valid_out  <= res.valid;
      was_filled <= res.filled;
      frame_last <= res.last;
    end
  end

endmodule

// File: design/mmhf_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhf_line_mem
// Line store: one word per column, four row slots per word, registered read.
// ----------------------------------------------------------------------------
module mmhf_line_mem (
  input  logic                            clk,
  input  logic                            re,
  input  logic [mmhf_pkg::COL_BITS-1:0]   raddr,
  output mmhf_pkg::line_word_t            rdata,
  input  logic                            we,
  input  logic [mmhf_pkg::COL_BITS-1:0]   waddr,
  input  mmhf_pkg::line_word_t            wdata
);

  mmhf_pkg::line_word_t mem [mmhf_pkg::MAX_ROW_LENGTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/mmhf_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhf_median
// Masked 3x3 median: registered pairwise order matrix, then rank select.
// ----------------------------------------------------------------------------
module mmhf_median (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic signed [mmhf_pkg::HEIGHT_BITS-1:0]    vals [mmhf_pkg::TAPS],
  input  logic [mmhf_pkg::TAPS-1:0]                  mask,
  input  mmhf_pkg::med_ctl_t                         ctl,
  output mmhf_pkg::result_t                          res
);

  logic signed [mmhf_pkg::HEIGHT_BITS-1:0] v_q [mmhf_pkg::TAPS];
  logic [mmhf_pkg::TAPS-1:0]               mask_q;
  logic [mmhf_pkg::TAPS-1:0]               prec_q [mmhf_pkg::TAPS];
  logic [mmhf_pkg::TAPS-1:0]               prec   [mmhf_pkg::TAPS];
  mmhf_pkg::med_ctl_t                      ctl_q;

  // prec[j][k]: element k sorts ahead of element j (ties by index)
  always_comb begin
    for (int j = 0; j < mmhf_pkg::TAPS; j++) begin
      for (int k = 0; k < mmhf_pkg::TAPS; k++) begin
        prec[j][k] = (k != j) &&
                     ((vals[k] < vals[j]) || ((vals[k] == vals[j]) && (k < j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_q    <= vals;
      mask_q <= mask;
      prec_q <= prec;
      ctl_q  <= ctl;
    end
  end

  logic [mmhf_pkg::RANK_BITS-1:0]          cnt;
  logic [mmhf_pkg::RANK_BITS-1:0]          half;
  logic [mmhf_pkg::RANK_BITS-1:0]          rank;
  logic signed [mmhf_pkg::HEIGHT_BITS-1:0] med;

  always_comb begin
    cnt  = mmhf_pkg::RANK_BITS'($countones(mask_q));
    half = cnt >> 1;
    med  = '0;
    for (int j = 0; j < mmhf_pkg::TAPS; j++) begin
      rank = mmhf_pkg::RANK_BITS'($countones(prec_q[j] & mask_q));
      if (mask_q[j] && (rank == half)) begin
        med = v_q[j];
      end
    end
    res.last   = ctl_q.last;
    res.filled = 1'b0;
    res.valid  = 1'b0;
    res.h      = '0;
    if (ctl_q.smooth) begin
      if (ctl_q.center_ok) begin
        res.valid = 1'b1;
        res.h     = med;
      end
    end else if (ctl_q.center_ok) begin
      res.valid = 1'b1;
      res.h     = v_q[4];
    end else if (ctl_q.spanned && (cnt >= mmhf_pkg::RANK_BITS'(mmhf_pkg::FILL_MIN))) begin
      res.valid  = 1'b1;
      res.filled = 1'b1;
      res.h      = med;
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for masked_median_hole_fill.
// Frames of random cell maps are sent at several frame sizes and in both
// modes. The random maps include holes, noise and extreme heights, and both
// channels idle at random. Each accepted input runs through a local
// predictor, and each accepted result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 10;
  localparam logic [mmhf_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic                                    in_valid = 1'b0;
  logic                                    in_stall;
  logic                                    kind = 1'b0;
  logic signed [mmhf_pkg::HEIGHT_BITS-1:0] height_in = '0;
  logic                                    valid_in = 1'b0;
  logic                                    out_valid;
  logic                                    out_stall = 1'b0;
  logic signed [mmhf_pkg::HEIGHT_BITS-1:0] height_out;
  logic                                    valid_out;
  logic                                    was_filled;
  logic                                    frame_last;
  logic                                    cfg_valid = 1'b0;
  logic                                    cfg_ready;
  logic [mmhf_pkg::CFG_IDX_BITS-1:0]       cfg_index = '0;
  logic [mmhf_pkg::DIM_BITS-1:0]           cfg_data = '0;

  masked_median_hole_fill uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  mmhf_pkg::cell_t line_mem [mmhf_pkg::SLOTS*mmhf_pkg::MAX_ROW_LENGTH];
  mmhf_pkg::cell_t win [5][5];
  int unsigned     in_col, in_row, out_pos;
  logic [mmhf_pkg::DIM_BITS-1:0] row_len_reg, row_cnt_reg;
  logic            smooth_reg;

  mmhf_pkg::result_t pending_results [$];
  int          predicted_count = 0;
  int          frames_done = 0;
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          hold_req = 0;
  bit          no_idle = 0;
  longint      base_h = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    return v < mmhf_pkg::MIN_DIM ? mmhf_pkg::MIN_DIM : (v > hi ? hi : v);
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_pos = 0;
    foreach (win[i, j]) win[i][j] = '0;
  endfunction

  function automatic bit cell_present(longint r, longint c, int dr, int dc,
                                      longint len, longint rows);
    longint rr, cc;
    rr = r + dr;
    cc = c + dc;
    if (rr < 0 || rr >= rows || cc < 0 || cc >= len) return 0;
    return win[dr+2][dc+2].valid;
  endfunction

  function automatic bit reach(longint r, longint c, int dr, int dc,
                               longint len, longint rows);
    return cell_present(r, c, dr, dc, len, rows) ||
           cell_present(r, c, 2*dr, 2*dc, len, rows);
  endfunction

  function automatic longint median(longint v[9], int n);
    longint x;
    int j;
    for (int i = 1; i < n; i++) begin
      x = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > x) begin
        v[j+1] = v[j];
        j--;
      end
      v[j+1] = x;
    end
    return v[n/2];
  endfunction

  // Advances the local copy of the block by one accepted input item.
  function automatic void predict_cell(bit k, logic signed [mmhf_pkg::HEIGHT_BITS-1:0] h,
                                       bit v);
    longint len, rows, total, lag, pos, r, c;
    int unsigned col;
    mmhf_pkg::cell_t nc;
    longint vals[9];
    int n;
    mmhf_pkg::result_t res;
    len   = clamp_dim(row_len_reg, mmhf_pkg::MAX_ROW_LENGTH);
    rows  = clamp_dim(row_cnt_reg, mmhf_pkg::MAX_ROWS);
    total = len * rows;
    lag   = 2 * len + 2;
    pos   = longint'(in_row) * len + in_col;
    if (pos == 0 && k) return;
    nc.valid = (!k && pos < total) ? v : 1'b0;
    nc.h = nc.valid ? h : '0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
    col = 32'(in_col % len);
    for (int i = 0; i < 4; i++)
      win[i][4] = line_mem[((in_row + i) & 3) * mmhf_pkg::MAX_ROW_LENGTH + col];
    win[4][4] = nc;
    line_mem[(in_row & 3) * mmhf_pkg::MAX_ROW_LENGTH + col] = nc;
    in_col = col + 1;
    if (in_col >= len) begin
      in_col = 0;
      in_row = (in_row + 1) & 14'h3fff;
    end
    if (pos < lag) return;

    r = out_pos / len;
    c = out_pos % len;
    n = 0;
    res = '0;
    if (!smooth_reg) begin
      if (cell_present(r, c, 0, 0, len, rows)) begin
        res.valid = 1'b1;
        res.h = win[2][2].h;
      end else if ((reach(r, c, 0, -1, len, rows) && reach(r, c, 0, 1, len, rows)) ||
                   (reach(r, c, -1, 0, len, rows) && reach(r, c, 1, 0, len, rows))) begin
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && cell_present(r, c, dr, dc, len, rows)) begin
              vals[n] = win[dr+2][dc+2].h;
              n++;
            end
          end
        end
        if (n >= mmhf_pkg::FILL_MIN) begin
          res.valid  = 1'b1;
          res.filled = 1'b1;
          res.h      = mmhf_pkg::HEIGHT_BITS'(median(vals, n));
        end
      end
    end else if (cell_present(r, c, 0, 0, len, rows)) begin
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (cell_present(r, c, dr, dc, len, rows)) begin
            vals[n] = win[dr+2][dc+2].h;
            n++;
          end
        end
      end
      res.valid = 1'b1;
      res.h = mmhf_pkg::HEIGHT_BITS'(median(vals, n));
    end
    res.last = (out_pos + 1 >= total);
    pending_results = {pending_results, res};
    predicted_count++;
    out_pos = (out_pos + 1) & 27'h7ffffff;
    if (res.last) begin
      restart_frame();
      frames_done++;
    end
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(bit k, logic signed [mmhf_pkg::HEIGHT_BITS-1:0] h, bit v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    height_in <= h;
    valid_in  <= v;
    do @(posedge clk); while (in_stall);
    predict_cell(k, h, v);
  endtask

  // in_valid is already low whenever this is called
  task automatic write_reg(logic [mmhf_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [mmhf_pkg::DIM_BITS-1:0] data);
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mmhf_pkg::REG_ROW_LENGTH: row_len_reg = data;
      mmhf_pkg::REG_ROW_COUNT:  row_cnt_reg = data;
      mmhf_pkg::REG_PASS_MODE:  smooth_reg  = data[0];
      default: ;
    endcase
    restart_frame();
  endtask

  function automatic logic signed [mmhf_pkg::HEIGHT_BITS-1:0] pick_height();
    int p;
    p = $urandom_range(0, 99);
    if (p == 0) return {1'b0, {(mmhf_pkg::HEIGHT_BITS-1){1'b1}}};
    if (p == 1) return {1'b1, {(mmhf_pkg::HEIGHT_BITS-1){1'b0}}};
    if (p < 6) return mmhf_pkg::HEIGHT_BITS'($urandom);
    base_h += $signed($urandom_range(0, 64)) - 32;
    return mmhf_pkg::HEIGHT_BITS'(base_h + $signed($urandom_range(0, 2048)) - 1024);
  endfunction

  // Feeds a frame with the given valid density (percent) and drains it with a
  // mix of flush items and stray cells. max_items > 0 cuts the frame short.
  task automatic run_frame(int density, int max_items, bit hold);
    int sent;
    int start_frames;
    longint len, rows;
    bit k;
    len  = clamp_dim(row_len_reg, mmhf_pkg::MAX_ROW_LENGTH);
    rows = clamp_dim(row_cnt_reg, mmhf_pkg::MAX_ROWS);
    sent = 0;
    start_frames = frames_done;
    base_h = $signed($urandom_range(0, 200000)) - 100000;
    while (frames_done == start_frames &&
           !(max_items > 0 && sent >= max_items)) begin
      if (sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (hold && sent == 100) hold_req = 1;
      if (longint'(in_row) * len + in_col >= len * rows)
        k = 1'($urandom_range(0, 1));
      else
        k = ($urandom_range(0, 99) < 2);
      send_item(k, pick_height(), $urandom_range(0, 99) < density);
      sent++;
    end
    in_valid <= 1'b0;
  endtask

  typedef struct {
    bit   k;
    int   h;
    bit   v;
    bit   quiet;  // row can produce no result: ignored flush or still inside the lag
  } stim_row_t;

  stim_row_t directed [18] = '{
    '{1, 0, 0, 1},           // flush before any cell
    '{0, 8388607, 1, 1}, '{0, -8388608, 1, 1}, '{0, 0, 0, 1},
    '{0, -1, 1, 1},      '{0, 0, 1, 1},        '{0, 123, 0, 1},
    '{1, 77, 1, 1},          // flush inside the frame acts as a hole
    '{0, 8388607, 1, 1}, '{0, -8388608, 1, 1}, '{0, -5, 0, 1},
    '{0, 5, 1, 1},       '{0, 1, 1, 1},        '{0, 8388607, 0, 1},
    '{0, -8388608, 0, 1}, '{0, 4096, 1, 1},    '{0, 4097, 1, 1},
    '{0, -4096, 1, 1}
  };

  // results
  always @(posedge clk) begin
    mmhf_pkg::result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result h=%0d v=%0b", height_out, valid_out);
      end else begin
        e = pending_results.pop_front();
        if (height_out !== e.h || valid_out !== e.valid || was_filled !== e.filled ||
            frame_last !== e.last) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp h=%0d v=%0b f=%0b l=%0b got h=%0d v=%0b f=%0b l=%0b",
                     e.h, e.valid, e.filled, e.last,
                     height_out, valid_out, was_filled, frame_last);
        end
      end
    end
  end

  // receiver stalls, with one long hold-off on request
  always begin
    int p;
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (400) @(posedge clk);
      hold_req = 0;
      out_stall <= 1'b0;
    end else if (!rst) begin
      p = $urandom_range(0, 99);
      if (no_idle) out_stall <= 1'b0;
      else if (p == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 50)) @(posedge clk);
        out_stall <= 1'b0;
      end else out_stall <= (p < 25);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int before_cnt;
    row_len_reg = 14'd8192;
    row_cnt_reg = 14'd8192;
    smooth_reg  = 1'b0;
    foreach (line_mem[i]) line_mem[i] = '0;
    restart_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(mmhf_pkg::REG_ROW_LENGTH, 14'd16);
    write_reg(mmhf_pkg::REG_ROW_COUNT, 14'd16);
    write_reg(mmhf_pkg::REG_PASS_MODE, 14'd0);
    foreach (directed[i]) begin
      before_cnt = predicted_count;
      send_item(directed[i].k, mmhf_pkg::HEIGHT_BITS'(directed[i].h), directed[i].v);
      if (directed[i].quiet && predicted_count != before_cnt) begin
        err_count++;
        if (err_count <= 10) $display("directed row %0d produced a result", i);
      end
    end
    run_frame(80, 0, 0);

    write_reg(mmhf_pkg::REG_ROW_LENGTH, 14'd0);   // clamps to minimum
    write_reg(mmhf_pkg::REG_PASS_MODE, 14'd1);
    run_frame(85, 0, 0);
    write_reg(mmhf_pkg::REG_ROW_LENGTH, 14'd19);
    write_reg(mmhf_pkg::REG_PASS_MODE, 14'd0);
    run_frame(50, 0, 1);
    write_reg(mmhf_pkg::REG_ROW_COUNT, 14'h3fff);
    write_reg(mmhf_pkg::REG_PASS_MODE, 14'd1);
    run_frame(95, 120, 0);
    write_reg(mmhf_pkg::REG_ROW_LENGTH, 14'd16);
    write_reg(mmhf_pkg::REG_ROW_COUNT, 14'd16);
    write_reg(mmhf_pkg::REG_PASS_MODE, 14'd0);
    run_frame(30, 100, 0);
    write_reg(REG_UNMAPPED, 14'h3fff);  // unmapped index only restarts the frame
    run_frame(90, 0, 0);

    // widest rows: short partial frames that stay inside the lag
    write_reg(mmhf_pkg::REG_ROW_LENGTH, 14'h3fff);
    write_reg(mmhf_pkg::REG_ROW_COUNT, 14'd0);
    run_frame(70, 40, 0);
    write_reg(mmhf_pkg::REG_ROW_LENGTH, 14'd8192);
    write_reg(mmhf_pkg::REG_PASS_MODE, 14'd1);
    run_frame(70, 40, 0);

    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
